[design/srv_pkg.sv]
// Shared types, constants and helper functions for the Schroeder reverb.
package srv_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int LEN_BITS       = 14;
  localparam int MUL_A_BITS     = SAMPLE_BITS + 1;
  localparam int MUL_B_BITS     = 18;
  localparam int ACC_BITS       = MUL_A_BITS + MUL_B_BITS + 1;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROOM         = 2'd0,
    REG_DAMPING      = 2'd1,
    REG_WET          = 2'd2,
    REG_ALLPASS_GAIN = 2'd3
  } cfg_reg_t;

  localparam logic [COEF_BITS-1:0] ROOM_RST         = 16'd45875;
  localparam logic [COEF_BITS-1:0] DAMPING_RST      = 16'd19661;
  localparam logic [COEF_BITS-1:0] WET_RST          = 16'd13107;
  localparam logic [COEF_BITS-1:0] ALLPASS_GAIN_RST = 16'd32768;

  // Feedback is 0.6 + 0.36 * room size; wet path scale 0.4
  localparam logic [COEF_BITS-1:0] FB_BASE   = 16'd39322;
  localparam logic [COEF_BITS-1:0] FB_SPAN   = 16'd23593;
  localparam logic [COEF_BITS-1:0] WET_SCALE = 16'd26214;

  localparam logic signed [ACC_BITS-1:0] SAT_MAX = ACC_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(32768);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_t;

  // Datapath operation for the current cycle
  typedef enum logic [4:0] {
    ST_NONE,
    ST_FB_MUL,
    ST_FB_LD,
    ST_C_RD,
    ST_C_M1,
    ST_C_M2,
    ST_C_LP,
    ST_C_M3,
    ST_C_WR,
    ST_SUM,
    ST_A_RD,
    ST_A_M,
    ST_A_WR,
    ST_W_M,
    ST_W_LD,
    ST_L_M1,
    ST_L_M2,
    ST_L_LD,
    ST_R_M1,
    ST_R_M2,
    ST_R_LD,
    ST_OUT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_status_t;

  // Comb delay lengths at 44.1 kHz
  function automatic logic [LEN_BITS-1:0] comb_len_lut(input logic [1:0] k);
    logic [LEN_BITS-1:0] n;
    case (k)
      2'd0:    n = 14'd1557;
      2'd1:    n = 14'd1617;
      2'd2:    n = 14'd1491;
      default: n = 14'd1422;
    endcase
    return n;
  endfunction

  // Allpass delay lengths at 44.1 kHz
  function automatic logic [LEN_BITS-1:0] ap_len_lut(input logic k);
    return k ? 14'd556 : 14'd225;
  endfunction

  // Round half up and drop 16 fraction bits
  function automatic logic signed [ACC_BITS-1:0] round16(input logic signed [ACC_BITS-1:0] x);
    return (x + RND_HALF) >>> 16;
  endfunction

  // Clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] c;
    if (v > SAT_MAX) c = SAT_MAX;
    else if (v < SAT_MIN) c = SAT_MIN;
    else c = v;
    return c[SAMPLE_BITS-1:0];
  endfunction

endpackage

[design/srv_ctrl.sv]
// Sequencer that steps the reverb datapath through one frame.
module srv_ctrl #(
  parameter int COMB_COUNT    = 4,
  parameter int ALLPASS_COUNT = 2,
  parameter int UNIT_BITS     = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  busy,
  output srv_pkg::dp_cmd_t      cmd,
  output logic [UNIT_BITS-1:0]  unit,
  input  srv_pkg::dp_status_t   status
);
  import srv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FB_MUL, S_FB_LD,
    S_C_RD, S_C_M1, S_C_M2, S_C_LP, S_C_M3, S_C_WR,
    S_SUM, S_A_RD, S_A_M, S_A_WR,
    S_W_M, S_W_LD, S_L_M1, S_L_M2, S_L_LD, S_R_M1, S_R_M2, S_R_LD, S_OUT
  } state_t;

  localparam logic [UNIT_BITS-1:0] COMB_LAST = UNIT_BITS'(COMB_COUNT - 1);
  localparam logic [UNIT_BITS-1:0] AP_LAST   = UNIT_BITS'(ALLPASS_COUNT - 1);

  state_t               state, state_next;
  logic [UNIT_BITS-1:0] unit_next;
  step_t                step, step_next;

  assign busy     = (state != S_IDLE);
  assign cmd.step = step;
  assign cmd.load = in_valid && !busy;

  // Next state and unit index
  always_comb begin
    state_next = state;
    unit_next  = unit;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_FB_MUL;
      S_FB_MUL: state_next = S_FB_LD;
      S_FB_LD:  begin state_next = S_C_RD; unit_next = '0; end
      S_C_RD:   state_next = S_C_M1;
      S_C_M1:   state_next = S_C_M2;
      S_C_M2:   state_next = S_C_LP;
      S_C_LP:   state_next = S_C_M3;
      S_C_M3:   state_next = S_C_WR;
      S_C_WR: begin
        if (unit == COMB_LAST) begin
          state_next = S_SUM;
          unit_next  = '0;
        end else begin
          state_next = S_C_RD;
          unit_next  = unit + 1'b1;
        end
      end
      S_SUM:    state_next = S_A_RD;
      S_A_RD:   state_next = S_A_M;
      S_A_M:    state_next = S_A_WR;
      S_A_WR: begin
        if (unit == AP_LAST) begin
          state_next = S_W_M;
          unit_next  = '0;
        end else begin
          state_next = S_A_RD;
          unit_next  = unit + 1'b1;
        end
      end
      S_W_M:    state_next = S_W_LD;
      S_W_LD:   state_next = S_L_M1;
      S_L_M1:   state_next = S_L_M2;
      S_L_M2:   state_next = S_L_LD;
      S_L_LD:   state_next = S_R_M1;
      S_R_M1:   state_next = S_R_M2;
      S_R_M2:   state_next = S_R_LD;
      S_R_LD:   state_next = S_OUT;
      S_OUT:    if (!status.out_hold) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath operation for the next state
  always_comb begin
    case (state_next)
      S_FB_MUL: step_next = ST_FB_MUL;
      S_FB_LD:  step_next = ST_FB_LD;
      S_C_RD:   step_next = ST_C_RD;
      S_C_M1:   step_next = ST_C_M1;
      S_C_M2:   step_next = ST_C_M2;
      S_C_LP:   step_next = ST_C_LP;
      S_C_M3:   step_next = ST_C_M3;
      S_C_WR:   step_next = ST_C_WR;
      S_SUM:    step_next = ST_SUM;
      S_A_RD:   step_next = ST_A_RD;
      S_A_M:    step_next = ST_A_M;
      S_A_WR:   step_next = ST_A_WR;
      S_W_M:    step_next = ST_W_M;
      S_W_LD:   step_next = ST_W_LD;
      S_L_M1:   step_next = ST_L_M1;
      S_L_M2:   step_next = ST_L_M2;
      S_L_LD:   step_next = ST_L_LD;
      S_R_M1:   step_next = ST_R_M1;
      S_R_M2:   step_next = ST_R_M2;
      S_R_LD:   step_next = ST_R_LD;
      S_OUT:    step_next = ST_OUT;
      default:  step_next = ST_NONE;
    endcase
  end

  // Hold state, unit index and registered command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      unit  <= '0;
      step  <= ST_NONE;
    end else begin
      state <= state_next;
      unit  <= unit_next;
      step  <= step_next;
    end
  end

endmodule

[design/srv_dp.sv]
// Reverb datapath: config registers, shared multiply-accumulate, delay memories.
module srv_dp #(
  parameter int COMB_COUNT        = 4,
  parameter int ALLPASS_COUNT     = 2,
  parameter int COMB_MAX_DEPTH    = 2048,
  parameter int ALLPASS_MAX_DEPTH = 1024,
  parameter int UNIT_BITS         = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [srv_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [srv_pkg::COEF_BITS-1:0]          cfg_data,
  input  srv_pkg::in_t                           in_data,
  input  srv_pkg::dp_cmd_t                       cmd,
  input  logic [UNIT_BITS-1:0]                   unit,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output srv_pkg::out_t                          out_data,
  output srv_pkg::dp_status_t                    status
);
  import srv_pkg::*;

  localparam int CUW = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
  localparam int AUW = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
  localparam int CPW = $clog2(COMB_MAX_DEPTH);
  localparam int APW = $clog2(ALLPASS_MAX_DEPTH);
  localparam int CMEM_DEPTH = COMB_COUNT * COMB_MAX_DEPTH;
  localparam int AMEM_DEPTH = ALLPASS_COUNT * ALLPASS_MAX_DEPTH;
  localparam int CAW = $clog2(CMEM_DEPTH);
  localparam int AAW = $clog2(AMEM_DEPTH);
  localparam int SUMW = SAMPLE_BITS + 4;
  localparam logic [LEN_BITS-1:0] CMAX = LEN_BITS'(COMB_MAX_DEPTH);
  localparam logic [LEN_BITS-1:0] AMAX = LEN_BITS'(ALLPASS_MAX_DEPTH);

  // Configuration registers
  logic [COEF_BITS-1:0] room_coef, damping, wet, allpass_gain;

  // Frame registers
  logic signed [SAMPLE_BITS-1:0] left, right, mono, s, wv, lo, ro;
  logic signed [SAMPLE_BITS-1:0] crd, ard, ap_y;
  logic signed [SUMW-1:0]        comb_sum;
  logic [COEF_BITS-1:0]          fb;
  logic signed [ACC_BITS-1:0]    acc, acc_next, rnd;

  // Per-line state
  logic signed [SAMPLE_BITS-1:0] lp [COMB_COUNT];
  logic [CPW-1:0]                comb_pos [COMB_COUNT];
  logic                          comb_wrap [COMB_COUNT];
  logic [APW-1:0]                ap_pos [ALLPASS_COUNT];
  logic                          ap_wrap [ALLPASS_COUNT];

  // Delay memories
  logic signed [SAMPLE_BITS-1:0] cmem [CMEM_DEPTH];
  logic signed [SAMPLE_BITS-1:0] amem [AMEM_DEPTH];

  logic [CUW-1:0]       cu;
  logic [AUW-1:0]       au;
  logic [31:0]          unit_ext;
  logic [LEN_BITS-1:0]  comb_len, ap_len, cpos_inc, apos_inc;
  logic                 cwraps, awraps;
  logic [CPW-1:0]       cpos_cur, cpos_next;
  logic [APW-1:0]       apos_cur, apos_next;
  logic [CAW-1:0]       caddr;
  logic [AAW-1:0]       aaddr;
  logic signed [SAMPLE_BITS-1:0] cy, ay;
  logic signed [MUL_A_BITS-1:0]  ma;
  logic signed [MUL_B_BITS-1:0]  mb;
  logic signed [MUL_A_BITS+MUL_B_BITS-1:0] prod;
  logic                 acc_add;
  logic signed [MUL_B_BITS-1:0]  damp_inv, dry_coef;
  logic signed [SAMPLE_BITS:0]   in_sum;

  assign status.out_hold = out_valid && out_stall;

  // Unit selection and delay line addressing
  assign cu       = unit[CUW-1:0];
  assign au       = unit[AUW-1:0];
  assign unit_ext = 32'(unit);
  assign comb_len = (comb_len_lut(unit_ext[1:0]) > CMAX) ? CMAX : comb_len_lut(unit_ext[1:0]);
  assign ap_len   = (ap_len_lut(unit_ext[0]) > AMAX) ? AMAX : ap_len_lut(unit_ext[0]);
  assign cpos_cur = comb_pos[cu];
  assign apos_cur = ap_pos[au];
  assign cpos_inc = LEN_BITS'(cpos_cur) + 1'b1;
  assign apos_inc = LEN_BITS'(apos_cur) + 1'b1;
  assign cwraps   = (cpos_inc == comb_len);
  assign awraps   = (apos_inc == ap_len);
  assign cpos_next = cwraps ? '0 : cpos_inc[CPW-1:0];
  assign apos_next = awraps ? '0 : apos_inc[APW-1:0];
  assign caddr    = CAW'(32'(cu) * COMB_MAX_DEPTH) + CAW'(cpos_cur);
  assign aaddr    = AAW'(32'(au) * ALLPASS_MAX_DEPTH) + AAW'(apos_cur);

  // Entries not yet written since reset read as zero
  assign cy = comb_wrap[cu] ? crd : '0;
  assign ay = ap_wrap[au] ? ard : '0;

  assign damp_inv = $signed(MUL_B_BITS'(18'h10000 - {2'b00, damping}));
  assign dry_coef = $signed(MUL_B_BITS'(18'h10000 - {2'b00, wet}));
  assign in_sum   = (SAMPLE_BITS+1)'(in_data.left_in) + (SAMPLE_BITS+1)'(in_data.right_in);

  // Select multiplier operands
  always_comb begin
    ma      = '0;
    mb      = '0;
    acc_add = 1'b0;
    case (cmd.step)
      ST_FB_MUL: begin
        ma = $signed(MUL_A_BITS'({1'b0, room_coef}));
        mb = $signed(MUL_B_BITS'(FB_SPAN));
      end
      ST_C_M1: begin
        ma = MUL_A_BITS'(cy);
        mb = damp_inv;
      end
      ST_C_M2: begin
        ma      = MUL_A_BITS'(lp[cu]);
        mb      = $signed(MUL_B_BITS'(damping));
        acc_add = 1'b1;
      end
      ST_C_M3: begin
        ma = MUL_A_BITS'(lp[cu]);
        mb = $signed(MUL_B_BITS'(fb));
      end
      ST_A_M: begin
        ma = MUL_A_BITS'(ay);
        mb = $signed(MUL_B_BITS'(allpass_gain));
      end
      ST_W_M: begin
        ma = MUL_A_BITS'(s);
        mb = $signed(MUL_B_BITS'(WET_SCALE));
      end
      ST_L_M1: begin
        ma = MUL_A_BITS'(left);
        mb = dry_coef;
      end
      ST_R_M1: begin
        ma = MUL_A_BITS'(right);
        mb = dry_coef;
      end
      ST_L_M2, ST_R_M2: begin
        ma      = MUL_A_BITS'(wv);
        mb      = $signed(MUL_B_BITS'(wet));
        acc_add = 1'b1;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  assign prod     = ma * mb;
  assign acc_next = (acc_add ? acc : '0) + ACC_BITS'(prod);
  assign rnd      = round16(acc);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      room_coef    <= ROOM_RST;
      damping      <= DAMPING_RST;
      wet          <= WET_RST;
      allpass_gain <= ALLPASS_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROOM:         room_coef    <= cfg_data;
        REG_DAMPING:      damping      <= cfg_data;
        REG_WET:          wet          <= cfg_data;
        REG_ALLPASS_GAIN: allpass_gain <= cfg_data;
        default:          room_coef    <= room_coef;
      endcase
    end
  end

  // Delay memories: registered read, one write per step
  always_ff @(posedge clk) begin
    if (cmd.step == ST_C_RD) crd <= cmem[caddr];
    if (cmd.step == ST_C_WR) cmem[caddr] <= sat(ACC_BITS'(mono) + rnd);
    if (cmd.step == ST_A_RD) ard <= amem[aaddr];
    if (cmd.step == ST_A_WR) amem[aaddr] <= sat(ACC_BITS'(s) + rnd);
  end

  // Line positions, fill flags and lowpass state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMB_COUNT; i++) begin
        comb_pos[i]  <= '0;
        comb_wrap[i] <= 1'b0;
        lp[i]        <= '0;
      end
      for (int i = 0; i < ALLPASS_COUNT; i++) begin
        ap_pos[i]  <= '0;
        ap_wrap[i] <= 1'b0;
      end
    end else begin
      case (cmd.step)
        ST_C_LP: lp[cu] <= sat(rnd);
        ST_C_WR: begin
          comb_pos[cu] <= cpos_next;
          if (cwraps) comb_wrap[cu] <= 1'b1;
        end
        ST_A_WR: begin
          ap_pos[au] <= apos_next;
          if (awraps) ap_wrap[au] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Frame payload and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left     <= in_data.left_in;
      right    <= in_data.right_in;
      mono     <= SAMPLE_BITS'(in_sum >>> 1);
      comb_sum <= '0;
    end
    case (cmd.step)
      ST_FB_MUL, ST_C_M2, ST_C_M3, ST_A_M, ST_W_M,
      ST_L_M1, ST_L_M2, ST_R_M1, ST_R_M2: acc <= acc_next;
      ST_C_M1: begin
        acc      <= acc_next;
        comb_sum <= comb_sum + SUMW'(cy);
      end
      ST_FB_LD: fb <= FB_BASE + rnd[COEF_BITS-1:0];
      ST_SUM:   s <= sat(ACC_BITS'(comb_sum));
      ST_A_WR:  s <= sat(ACC_BITS'(ap_y) - ACC_BITS'(s));
      ST_W_LD:  wv <= rnd[SAMPLE_BITS-1:0];
      ST_L_LD:  lo <= sat(rnd);
      ST_R_LD:  ro <= sat(rnd);
      default:  ;
    endcase
    if (cmd.step == ST_A_M) ap_y <= ay;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step == ST_OUT && !status.out_hold) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == ST_OUT && !status.out_hold) begin
      out_data.left_out  <= lo;
      out_data.right_out <= ro;
    end
  end

endmodule

[design/schroeder_reverb_top.sv]
// Top level of the Schroeder reverb: sequencer plus datapath.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data   (left_in, right_in)
//  out      output     out_valid / out_stall  out_data  (left_out, right_out)
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// Frames are processed one at a time: the input stays stalled from the frame being taken
// until its result is loaded into the output register. The single shared multiplier and
// one port per delay memory are why each frame is stepped through in sequence.
// Reset is synchronous; delay lines read as zero until first written, no clear pass.
// A stalled output holds the datapath in its last step until the result is taken.
module schroeder_reverb_top #(
  parameter int COMB_COUNT        = 4,
  parameter int ALLPASS_COUNT     = 2,
  parameter int COMB_MAX_DEPTH    = 2048,
  parameter int ALLPASS_MAX_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  srv_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output srv_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [srv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srv_pkg::COEF_BITS-1:0]      cfg_data
);
  import srv_pkg::*;

  localparam int MAX_COUNT = (COMB_COUNT > ALLPASS_COUNT) ? COMB_COUNT : ALLPASS_COUNT;
  localparam int UNIT_BITS = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [UNIT_BITS-1:0] unit;
  logic                 busy;

  assign in_stall = busy;

  srv_ctrl #(
    .COMB_COUNT    (COMB_COUNT),
    .ALLPASS_COUNT (ALLPASS_COUNT),
    .UNIT_BITS     (UNIT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (busy),
    .cmd      (cmd),
    .unit     (unit),
    .status   (status)
  );

  srv_dp #(
    .COMB_COUNT        (COMB_COUNT),
    .ALLPASS_COUNT     (ALLPASS_COUNT),
    .COMB_MAX_DEPTH    (COMB_MAX_DEPTH),
    .ALLPASS_MAX_DEPTH (ALLPASS_MAX_DEPTH),
    .UNIT_BITS         (UNIT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .unit      (unit),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

[design/srv_checker.sv]
// Port-level checks for the reverb top level, bound to it.
module srv_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input srv_pkg::out_t out_data
);

  // Reset leaves no result pending and the input open
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // Block one frame at a time once a transaction is taken
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while frame in progress");

  // A result appears only at the end of frame processing
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(in_stall))
    else $error("result without a frame in progress");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind schroeder_reverb_top srv_checker u_srv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
